[design/frm_rot_pkg.sv]
package frm_rot_pkg;

  localparam int MAX_DIM    = 64;
  localparam int PIXEL_BITS = 32;
  localparam int CFG_W      = 7;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int IDX_W      = 6;
  localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic REG_HEIGHT = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

  typedef struct packed {
    logic        action;
    logic [31:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]      pixel_out;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic             last_of_frame;
  } out_beat_t;

  typedef struct packed {
    logic                  is_read;
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_BITS-1:0] pixel;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic                  last;
  } op_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

[design/frm_rot_front.sv]
module frm_rot_front
  import frm_rot_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_beat_t         in_beat_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output op_t              push_op_o
);

  logic [CFG_W-1:0]   height_q, width_q;
  logic [ADDR_W-1:0]  load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0]   row_q, row_d, col_q, col_d;

  logic [DIM_W-1:0]   h, w, hm1c;
  logic [2*DIM_W-1:0] hw_prod, addr_prod;
  logic [ADDR_W:0]    total, lc_inc;
  logic [ADDR_W-1:0]  lc_cur, rd_addr;
  logic [IDX_W-1:0]   r_cur, c_cur;
  logic [DIM_W-1:0]   c_inc, r_inc;
  logic               wrap, last, accept;

  assign h       = eff_dim(height_q);
  assign w       = eff_dim(width_q);
  assign hw_prod = h * w;
  assign total   = hw_prod[ADDR_W:0];

  // load side
  assign lc_cur = ({1'b0, load_cnt_q} >= total) ? '0 : load_cnt_q;
  assign lc_inc = {1'b0, lc_cur} + (ADDR_W+1)'(1);

  // read side: rotated frame is w rows by h columns
  assign wrap      = ({1'b0, row_q} >= w) || ({1'b0, col_q} >= h);
  assign r_cur     = wrap ? '0 : row_q;
  assign c_cur     = wrap ? '0 : col_q;
  assign hm1c      = h - DIM_W'(1) - {1'b0, c_cur};
  assign addr_prod = hm1c * w + (2*DIM_W)'(r_cur);
  assign rd_addr   = addr_prod[ADDR_W-1:0];
  assign last      = ({1'b0, r_cur} == w - DIM_W'(1)) && ({1'b0, c_cur} == h - DIM_W'(1));
  assign c_inc     = {1'b0, c_cur} + DIM_W'(1);
  assign r_inc     = {1'b0, r_cur} + DIM_W'(1);

  assign accept = in_valid_i && push_ready_i;

  always_comb begin
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    if (accept) begin
      if (in_beat_i.action == ACT_LOAD) begin
        load_cnt_d = (lc_inc >= total) ? '0 : lc_inc[ADDR_W-1:0];
      end else begin
        if (c_inc >= h) begin
          col_d = '0;
          row_d = (r_inc >= w) ? '0 : r_inc[IDX_W-1:0];
        end else begin
          col_d = c_inc[IDX_W-1:0];
          row_d = r_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q   <= DIM_RESET;
      width_q    <= DIM_RESET;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HEIGHT: height_q <= cfg_data_i;
          REG_WIDTH:  width_q  <= cfg_data_i;
          default: ;
        endcase
      end
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

  always_comb begin
    push_op_o.is_read = (in_beat_i.action == ACT_READ);
    push_op_o.addr    = push_op_o.is_read ? rd_addr : lc_cur;
    push_op_o.pixel   = PIXEL_BITS'(in_beat_i.pixel_in);
    push_op_o.row     = r_cur;
    push_op_o.col     = c_cur;
    push_op_o.last    = last;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

[design/frm_rot_queue.sv]
module frm_rot_queue
  import frm_rot_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_op_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  op_t               slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[design/frm_rot_back.sv]
module frm_rot_back
  import frm_rot_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  op_t       pop_op_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic [PIXEL_BITS-1:0] mem [MAX_DIM*MAX_DIM];
  logic [PIXEL_BITS-1:0] rdata_q;
  logic [IDX_W-1:0]      row_q, col_q;
  logic                  last_q;
  logic                  out_v_q;
  logic                  slot_free, pop_rd, pop_wr;

  // a read may issue only when the output register frees up this cycle
  assign slot_free   = !out_v_q || out_ready_i;
  assign pop_ready_o = !pop_op_i.is_read || slot_free;
  assign pop_rd      = pop_valid_i && pop_op_i.is_read && slot_free;
  assign pop_wr      = pop_valid_i && !pop_op_i.is_read;

  always_ff @(posedge clk_i) begin
    if (pop_wr) begin
      mem[pop_op_i.addr] <= pop_op_i.pixel;
    end
    if (pop_rd) begin
      rdata_q <= mem[pop_op_i.addr];
      row_q   <= pop_op_i.row;
      col_q   <= pop_op_i.col;
      last_q  <= pop_op_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pop_rd) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_valid_o              = out_v_q;
  assign out_beat_o.pixel_out     = 32'(rdata_q);
  assign out_beat_o.out_row       = row_q;
  assign out_beat_o.out_col       = col_q;
  assign out_beat_o.last_of_frame = last_q;

`ifndef SYNTHESIS
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_rd |=> out_v_q)
    else $error("issued read did not reach the output register");

  a_write_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_i && !pop_op_i.is_read) |-> pop_ready_o)
    else $error("store write stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |-> !pop_rd)
    else $error("pending result overwritten");
`endif

endmodule

[design/frame_rotate_90_clockwise_top.sv]
// channel | direction | handshake                   | payload
// in      | input     | in_valid_i / in_ready_o     | in_beat_i  (action, pixel_in)
// out     | output    | out_valid_o / out_ready_i   | out_beat_o (pixel_out, row, col, last)
// cfg     | input     | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// One beat per clock each way, set by the single store port, unless a stall holds it.
// A read beat passes through the op queue and the output register; loads give no beat.
// Reset clears counters and control only; the frame store is not cleared.
// A 4-entry op queue sits between front and store; an output stall holds the queue
// only while a read sits at its head, and the input stalls once the queue is full.
module frame_rotate_90_clockwise_top
  import frm_rot_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_beat_t         in_beat_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_beat_t        out_beat_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  op_t  push_op, pop_op;

  frm_rot_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  frm_rot_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  frm_rot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

[dv/frame_rotate_90_clockwise_top_tb.sv]
`timescale 1ns / 100ps

module frame_rotate_90_clockwise_top_tb;
  import frm_rot_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BEATS = 1800;

  class rotated_frame_model;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] width_reg;
    logic [31:0]      pixels [MAX_DIM*MAX_DIM];
    bit               loaded [MAX_DIM*MAX_DIM];
    int unsigned      load_ptr;
    int unsigned      row;
    int unsigned      col;
    out_beat_t        rotated_pending[$];
    int               errors;

    function new();
      height_reg = DIM_RESET;
      width_reg  = DIM_RESET;
      load_ptr   = 0;
      row        = 0;
      col        = 0;
      errors     = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function int unsigned dim_of(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] v);
      if (idx == REG_HEIGHT) begin
        height_reg = v;
      end else begin
        width_reg = v;
      end
    endfunction

    // source address of the next rotated pixel, after wrap
    function int unsigned read_addr(output int unsigned r, output int unsigned c);
      int unsigned h;
      int unsigned w;
      h = dim_of(height_reg);
      w = dim_of(width_reg);
      r = row;
      c = col;
      if (r >= w || c >= h) begin
        r = 0;
        c = 0;
      end
      return (h - 1 - c) * w + r;
    endfunction

    function bit read_allowed();
      int unsigned r;
      int unsigned c;
      return loaded[read_addr(r, c)];
    endfunction

    function void note_beat(in_beat_t b);
      int unsigned h;
      int unsigned w;
      int unsigned total;
      int unsigned addr;
      int unsigned r;
      int unsigned c;
      out_beat_t   e;
      h = dim_of(height_reg);
      w = dim_of(width_reg);
      total = h * w;
      if (b.action == ACT_LOAD) begin
        if (load_ptr >= total) load_ptr = 0;
        pixels[load_ptr] = b.pixel_in;
        loaded[load_ptr] = 1'b1;
        load_ptr++;
        if (load_ptr >= total) load_ptr = 0;
      end else begin
        addr = read_addr(r, c);
        e.pixel_out     = pixels[addr];
        e.out_row       = r[IDX_W-1:0];
        e.out_col       = c[IDX_W-1:0];
        e.last_of_frame = (r == w - 1) && (c == h - 1);
        rotated_pending.push_back(e);
        c++;
        if (c >= h) begin
          c = 0;
          r++;
          if (r >= w) r = 0;
        end
        row = r;
        col = c;
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t e;
      if (rotated_pending.size() == 0) begin
        $error("unexpected output beat: pixel_out %h row %0d col %0d",
               got.pixel_out, got.out_row, got.out_col);
        errors++;
        return;
      end
      e = rotated_pending.pop_front();
      if (got.pixel_out !== e.pixel_out) begin
        $error("pixel_out: expected %h, got %h", e.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.out_row !== e.out_row) begin
        $error("out_row: expected %0d, got %0d", e.out_row, got.out_row);
        errors++;
      end
      if (got.out_col !== e.out_col) begin
        $error("out_col: expected %0d, got %0d", e.out_col, got.out_col);
        errors++;
      end
      if (got.last_of_frame !== e.last_of_frame) begin
        $error("last_of_frame: expected %0d, got %0d", e.last_of_frame, got.last_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_HEIGHT;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  in_beat_t         in_beat_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_beat_t        out_beat_o;

  rotated_frame_model board;
  int  beats_sent = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  frame_rotate_90_clockwise_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && board != null && out_valid_o && out_ready_i) begin
      board.check_beat(out_beat_o);
    end
  end

  // reads that would hit an unwritten store entry turn into loads
  task automatic send_beat(input logic action, input logic [31:0] pixel);
    in_beat_t b;
    b.action = action;
    b.pixel_in = pixel;
    if (action == ACT_READ && !board.read_allowed()) b.action = ACT_LOAD;
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_beat(b);
    beats_sent++;
    calm = (beats_sent >= 700 && beats_sent < 1000);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w);
    in_valid_i <= 1'b0;
    while (board.rotated_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    board.set_reg(REG_HEIGHT, h);
    cfg_idx_i  <= REG_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    board.set_reg(REG_WIDTH, w);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(127);
      2: return CFG_W'(MAX_DIM);
      3: return CFG_W'(1);
      4: return CFG_W'($urandom_range(13, MAX_DIM));
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] w;
    int unsigned      total;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero dimensions act as 1x1
    set_dims('0, '0);
    send_beat(ACT_LOAD, 32'hFFFF_FFFF);
    send_beat(ACT_READ, '0);
    send_beat(ACT_LOAD, 32'h0000_0000);
    send_beat(ACT_READ, '0);

    set_dims(CFG_W'(2), CFG_W'(3));
    send_beat(ACT_LOAD, 32'h5555_5555);
    send_beat(ACT_LOAD, 32'hAAAA_AAAA);
    send_beat(ACT_LOAD, 32'hFFFF_FFFF);
    send_beat(ACT_LOAD, 32'h0000_0000);
    send_beat(ACT_LOAD, 32'h8000_0001);
    send_beat(ACT_LOAD, 32'h7FFF_FFFE);
    repeat (3) send_beat(ACT_READ, '0);

    // dimension change in the middle of a rotated frame
    set_dims(CFG_W'(3), CFG_W'(2));
    repeat (3) send_beat(ACT_READ, '0);

    // oversized width clamps to MAX_DIM
    set_dims(CFG_W'(1), CFG_W'(127));
    repeat (4) send_beat(ACT_READ, '0);
    send_beat(ACT_LOAD, $urandom());

    while (beats_sent < RANDOM_BEATS) begin
      h = pick_dim();
      w = pick_dim();
      if (board.dim_of(h) * board.dim_of(w) > 256) w = CFG_W'($urandom_range(1, 4));
      set_dims(h, w);
      total = board.dim_of(h) * board.dim_of(w);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 9) < 7) begin
          repeat (total) send_beat(ACT_LOAD, $urandom());
          repeat (total) send_beat(ACT_READ, $urandom());
        end else begin
          repeat ($urandom_range(1, 2 * total)) begin
            send_beat(1'($urandom_range(0, 1)), $urandom());
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    while (board.rotated_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
